[hdl/memory_request_queue_cancel_defines.svh]
// Assertion macros shared by the memory request queue modules.
// MRQC_ASSERT checks a property on every clock edge outside reset.
// MRQC_ASSERT_IMP checks that an antecedent implies a consequent in the same cycle.
`ifndef MEMORY_REQUEST_QUEUE_CANCEL_DEFINES_SVH
`define MEMORY_REQUEST_QUEUE_CANCEL_DEFINES_SVH

`ifndef SYNTH
`define MRQC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed");
`define MRQC_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`else
`define MRQC_ASSERT(name, clk, rst, prop)
`define MRQC_ASSERT_IMP(name, clk, rst, ante, cons)
`endif

`endif

[hdl/mrqc_pkg.sv]
package mrqc_pkg;

  localparam int OP_W    = 2;
  localparam int ID_W    = 8;
  localparam int ADDR_W  = 10;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;
  localparam int SIZE_W  = 11;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_MEM_WORDS   = 1024;

  localparam logic [SIZE_W-1:0] RESET_RAM_SIZE = SIZE_W'(1024);

  localparam logic RK_READ = 1'b0;
  localparam logic RK_DROP = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    Q_NONE,
    Q_SHIFT,
    Q_APPEND,
    Q_KILL,
    Q_COMPACT
  } qop_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPACT,
    ST_RESULT
  } st_t;

  typedef struct packed {
    logic              is_write;
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
  } entry_t;

  // The entry carries the request to append, and its address is the cancel address.
  typedef struct packed {
    qop_t   op;
    entry_t ent;
  } queue_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic compact;
  } queue_stat_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

endpackage

[hdl/mrqc_cell.sv]
module mrqc_cell
  import mrqc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  queue_cmd_t cmd,
  input  logic       lower_valid,
  input  logic       upper_valid,
  input  entry_t     upper_ent,
  output logic       valid,
  output entry_t     ent
);

  logic   valid_next;
  entry_t ent_next;
  logic   kill_hit;

  assign kill_hit = valid && !ent.is_write && (ent.addr == cmd.ent.addr);

  always_comb begin
    valid_next = valid;
    ent_next   = ent;
    case (cmd.op)
      Q_SHIFT: begin
        valid_next = upper_valid;
        ent_next   = upper_ent;
      end
      Q_APPEND: begin
        if (!valid && lower_valid) begin
          valid_next = 1'b1;
          ent_next   = cmd.ent;
        end
      end
      Q_KILL: begin
        if (kill_hit) begin
          valid_next = 1'b0;
        end
      end
      Q_COMPACT: begin
        // An empty slot pulls from above; a full slot over an empty one hands down.
        if (!valid) begin
          valid_next = upper_valid;
          ent_next   = upper_ent;
        end else if (!lower_valid) begin
          valid_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

[hdl/mrqc_queue.sv]
`include "memory_request_queue_cancel_defines.svh"

module mrqc_queue
  import mrqc_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int QW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  queue_cmd_t    cmd,
  output entry_t        head,
  output queue_stat_t   stat,
  output logic [QW-1:0] count
);

  logic   v [QUEUE_DEPTH];
  entry_t e [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    logic   lower_v;
    logic   upper_v;
    entry_t upper_e;

    if (i == 0) begin : g_bottom
      assign lower_v = 1'b1;
    end else begin : g_mid_lo
      assign lower_v = v[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_top
      assign upper_v = 1'b0;
      assign upper_e = '0;
    end else begin : g_mid_hi
      assign upper_v = v[i+1];
      assign upper_e = e[i+1];
    end

    mrqc_cell u_slot (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .lower_valid (lower_v),
      .upper_valid (upper_v),
      .upper_ent   (upper_e),
      .valid       (v[i]),
      .ent         (e[i])
    );
  end

  assign head = e[0];

  // When the chain is compact the valid bits form a thermometer code.
  always_comb begin
    logic hole;
    logic [QW-1:0] cnt;
    hole = 1'b0;
    cnt  = '0;
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      hole = hole | (!v[i] && v[i+1]);
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (v[i] && ((i == QUEUE_DEPTH - 1) || !v[(i + 1) % QUEUE_DEPTH])) begin
        cnt = cnt | QW'(i + 1);
      end
    end
    stat.compact = !hole;
    stat.full    = v[QUEUE_DEPTH-1];
    stat.empty   = !v[0];
    count        = cnt;
  end

  `MRQC_ASSERT_IMP(a_append_not_full, clk, rst, cmd.op == Q_APPEND, !stat.full)
  `MRQC_ASSERT_IMP(a_shift_not_empty, clk, rst, cmd.op == Q_SHIFT, !stat.empty)
  `MRQC_ASSERT(a_shift_count, clk, rst,
    (cmd.op == Q_SHIFT && stat.compact) |=> (count == QW'($past(count) - QW'(1))))

endmodule

[hdl/mrqc_mem.sv]
module mrqc_mem
  import mrqc_pkg::*;
#(
  parameter int MEM_WORDS = DEF_MEM_WORDS,
  parameter int AW        = $clog2(MEM_WORDS),
  parameter int PW        = $clog2(MEM_WORDS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [PW-1:0]     old_size,
  input  logic [PW-1:0]     new_size,
  input  mem_req_t          req,
  input  logic [AW-1:0]     addr,
  output logic [DATA_W-1:0] rdata,
  output logic              busy
);

  logic [DATA_W-1:0] words [MEM_WORDS];
  logic [PW-1:0] ptr;
  logic [PW-1:0] ptr_next;
  logic [PW-1:0] hi;
  logic [PW-1:0] hi_next;
  logic [PW-1:0] ptr_adv;

  assign busy    = ptr < hi;
  assign ptr_adv = busy ? PW'(ptr + PW'(1)) : ptr;

  // A shrink clears the words between the new and the old size. If a pass is
  // already running, the two ranges are merged; words between them are zero anyway.
  always_comb begin
    ptr_next = ptr_adv;
    hi_next  = hi;
    if (cfg_we && (new_size < old_size)) begin
      if (busy) begin
        ptr_next = (new_size < ptr_adv) ? new_size : ptr_adv;
        hi_next  = (old_size > hi) ? old_size : hi;
      end else begin
        ptr_next = new_size;
        hi_next  = old_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      hi  <= PW'(MEM_WORDS);
    end else begin
      ptr <= ptr_next;
      hi  <= hi_next;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      words[ptr[AW-1:0]] <= '0;
    end else if (req.wr) begin
      words[addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rdata <= words[addr];
    end
  end

endmodule

[hdl/memory_request_queue_cancel.sv]
// Request queue in front of a word memory. A request transaction is accepted
// when req_valid is high and req_stall is low; results leave on the rsp channel
// through an output register, so a waiting result does not block the next
// request unless that request also produces a result. Read and write requests
// are appended to the queue, or give a drop result when the queue is full. A
// tick serving a write gives no result; a tick serving a read is answered
// through the registered read port of the memory. A cancel clears the matching
// reads in the chain of queue slots and then stalls requests while entries
// slide down one slot at a time to close the gaps. After reset the memory is
// cleared one word a cycle, and lowering ram_size clears the words given up
// the same way; requests are stalled during that pass, while ram_size writes
// are taken.
`include "memory_request_queue_cancel_defines.svh"

module memory_request_queue_cancel
  import mrqc_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int MEM_WORDS   = DEF_MEM_WORDS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     ram_size_we,
  input  logic [SIZE_W-1:0]        ram_size_wdata,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [OP_W-1:0]          operation,
  input  logic [ID_W-1:0]          requester_id,
  input  logic [ADDR_W-1:0]        address,
  input  logic signed [DATA_W-1:0] write_value,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic                     result_kind,
  output logic [ID_W-1:0]          reply_id,
  output logic [ADDR_W-1:0]        reply_address,
  output logic signed [DATA_W-1:0] read_value,
  output logic [COUNT_W-1:0]       queue_count
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam int PW = $clog2(MEM_WORDS + 1);
  localparam int CW = (PW > SIZE_W) ? PW : SIZE_W;
  localparam int XW = (AW > ADDR_W) ? AW : ADDR_W;
  localparam int QW = $clog2(QUEUE_DEPTH + 1);

  st_t state;
  st_t state_next;

  logic [SIZE_W-1:0] ram_size;
  logic [CW-1:0]     mem_limit;
  logic [CW-1:0]     size_cur;
  logic [CW-1:0]     size_wr;
  logic [CW-1:0]     use_cur;
  logic [CW-1:0]     use_wr;

  queue_cmd_t    qcmd;
  queue_stat_t   qstat;
  entry_t        head;
  logic [QW-1:0] qcount;
  logic          head_in_range;

  mem_req_t          mreq;
  logic [XW-1:0]     head_addr_x;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_rdata;
  logic              mem_busy;

  logic req_acc;
  logic out_load;

  logic               stage_load;
  logic               stage_kind;
  logic [ID_W-1:0]    stage_id;
  logic [ADDR_W-1:0]  stage_addr;
  logic [COUNT_W-1:0] stage_count;
  logic               stage_read_ok;

  logic               res_kind;
  logic [ID_W-1:0]    res_id;
  logic [ADDR_W-1:0]  res_addr;
  logic [COUNT_W-1:0] res_count;
  logic               res_read_ok;

  // Size in use is the register clamped to the memory depth.
  assign mem_limit = CW'(MEM_WORDS);
  assign size_cur  = CW'(ram_size);
  assign size_wr   = CW'(ram_size_wdata);
  assign use_cur   = (size_cur > mem_limit) ? mem_limit : size_cur;
  assign use_wr    = (size_wr > mem_limit) ? mem_limit : size_wr;

  assign head_in_range = CW'(head.addr) < use_cur;
  assign head_addr_x   = XW'(head.addr);
  assign mem_addr      = head_addr_x[AW-1:0];

  assign req_stall = (state != ST_IDLE) || mem_busy;
  assign req_acc   = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_size <= RESET_RAM_SIZE;
    end else if (ram_size_we) begin
      ram_size <= ram_size_wdata;
    end
  end

  mrqc_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .QW          (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .cmd   (qcmd),
    .head  (head),
    .stat  (qstat),
    .count (qcount)
  );

  mrqc_mem #(
    .MEM_WORDS (MEM_WORDS),
    .AW        (AW),
    .PW        (PW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (ram_size_we),
    .old_size (PW'(use_cur)),
    .new_size (PW'(use_wr)),
    .req      (mreq),
    .addr     (mem_addr),
    .rdata    (mem_rdata),
    .busy     (mem_busy)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_acc) begin
          case (op_t'(operation))
            OP_TICK: begin
              if (!qstat.empty && !head.is_write) begin
                state_next = ST_RESULT;
              end
            end
            OP_READ, OP_WRITE: begin
              if (qstat.full) begin
                state_next = ST_RESULT;
              end
            end
            OP_CANCEL: begin
              state_next = ST_COMPACT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_COMPACT: begin
        if (qstat.compact) begin
          state_next = ST_IDLE;
        end
      end
      ST_RESULT: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    qcmd.op           = Q_NONE;
    qcmd.ent.is_write = (op_t'(operation) == OP_WRITE);
    qcmd.ent.id       = requester_id;
    qcmd.ent.addr     = address;
    qcmd.ent.value    = write_value;
    mreq.rd           = 1'b0;
    mreq.wr           = 1'b0;
    mreq.wdata        = head.value;
    stage_load        = 1'b0;
    stage_kind        = RK_READ;
    stage_id          = head.id;
    stage_addr        = head.addr;
    stage_count       = COUNT_W'(qcount - QW'(1));
    stage_read_ok     = head_in_range;
    out_load          = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_acc) begin
          case (op_t'(operation))
            OP_TICK: begin
              if (!qstat.empty) begin
                qcmd.op = Q_SHIFT;
                if (head.is_write) begin
                  mreq.wr = head_in_range;
                end else begin
                  mreq.rd    = 1'b1;
                  stage_load = 1'b1;
                end
              end
            end
            OP_READ, OP_WRITE: begin
              if (qstat.full) begin
                stage_load    = 1'b1;
                stage_kind    = RK_DROP;
                stage_id      = requester_id;
                stage_addr    = address;
                stage_count   = COUNT_W'(qcount);
                stage_read_ok = 1'b0;
              end else begin
                qcmd.op = Q_APPEND;
              end
            end
            OP_CANCEL: begin
              qcmd.op = Q_KILL;
            end
            default: begin
            end
          endcase
        end
      end
      ST_COMPACT: begin
        qcmd.op = Q_COMPACT;
      end
      ST_RESULT: begin
        out_load = !rsp_valid || !rsp_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load) begin
      res_kind    <= stage_kind;
      res_id      <= stage_id;
      res_addr    <= stage_addr;
      res_count   <= stage_count;
      res_read_ok <= stage_read_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // The read word stays in the memory output register until the next read tick.
  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind   <= res_kind;
      reply_id      <= res_id;
      reply_address <= res_addr;
      queue_count   <= res_count;
      read_value    <= res_read_ok ? mem_rdata : '0;
    end
  end

  `MRQC_ASSERT_IMP(a_idle_compact, clk, rst, state == ST_IDLE, qstat.compact)
  `MRQC_ASSERT_IMP(a_no_write_in_clear, clk, rst, mreq.wr, !mem_busy)
  `MRQC_ASSERT_IMP(a_drop_reads_zero, clk, rst,
    rsp_valid && (result_kind == RK_DROP), read_value == '0)

endmodule

[verif/tb_memory_request_queue_cancel.sv]
`timescale 1ns / 1ps

module tb_memory_request_queue_cancel;
  import mrqc_pkg::*;

  localparam int QUIET_CYCLES  = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 190;
  localparam int DIRECTED_ROWS = 13;

  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    id;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  value;
    logic [COUNT_W-1:0] count;
  } reply_t;

  typedef struct {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
    int                copies;
    bit                golden;
    reply_t            want;
  } directed_row_t;

  logic                     clk;
  logic                     rst;
  logic                     ram_size_we;
  logic [SIZE_W-1:0]        ram_size_wdata;
  logic                     req_valid;
  logic                     req_stall;
  logic [OP_W-1:0]          operation;
  logic [ID_W-1:0]          requester_id;
  logic [ADDR_W-1:0]        address;
  logic signed [DATA_W-1:0] write_value;
  logic                     rsp_valid;
  logic                     rsp_stall;
  logic                     result_kind;
  logic [ID_W-1:0]          reply_id;
  logic [ADDR_W-1:0]        reply_address;
  logic signed [DATA_W-1:0] read_value;
  logic [COUNT_W-1:0]       queue_count;

  // Shadow copy of the queue, the memory and the size register.
  entry_t            shadow_queue[$];
  logic [DATA_W-1:0] shadow_mem[DEF_MEM_WORDS];
  logic [SIZE_W-1:0] shadow_size;

  reply_t pending_replies[$];
  reply_t oldest_reply;
  int     mismatches;
  int     send_idle_pct;
  int     stall_pct;
  logic   holding;

  directed_row_t     directed[DIRECTED_ROWS];
  logic [SIZE_W-1:0] ram_sizes[PHASES];

  memory_request_queue_cancel dut (
    .clk            (clk),
    .rst            (rst),
    .ram_size_we    (ram_size_we),
    .ram_size_wdata (ram_size_wdata),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .operation      (operation),
    .requester_id   (requester_id),
    .address        (address),
    .write_value    (write_value),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .result_kind    (result_kind),
    .reply_id       (reply_id),
    .reply_address  (reply_address),
    .read_value     (read_value),
    .queue_count    (queue_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int words_in_use();
    return (shadow_size > SIZE_W'(DEF_MEM_WORDS)) ? DEF_MEM_WORDS : int'(shadow_size);
  endfunction

  // Shrinking the size clears the words given up.
  function automatic void shadow_set_size(input logic [SIZE_W-1:0] size);
    int old_words;
    int new_words;
    old_words = words_in_use();
    shadow_size = size;
    new_words = words_in_use();
    for (int i = new_words; i < old_words; i++) shadow_mem[i] = '0;
  endfunction

  function automatic bit queue_memory_step(input op_t op, input logic [ID_W-1:0] id,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [DATA_W-1:0] value,
                                           output reply_t reply);
    entry_t head;
    entry_t kept[$];
    bit     in_range;
    reply = '0;
    case (op)
      OP_TICK: begin
        if (shadow_queue.size() == 0) return 1'b0;
        head = shadow_queue.pop_front();
        in_range = int'(head.addr) < words_in_use();
        if (head.is_write) begin
          if (in_range) shadow_mem[head.addr] = head.value;
          return 1'b0;
        end
        reply.kind  = RK_READ;
        reply.id    = head.id;
        reply.addr  = head.addr;
        reply.value = in_range ? shadow_mem[head.addr] : '0;
        reply.count = COUNT_W'(shadow_queue.size());
        return 1'b1;
      end
      OP_CANCEL: begin
        foreach (shadow_queue[i]) begin
          if (shadow_queue[i].is_write || shadow_queue[i].addr != addr)
            kept.push_back(shadow_queue[i]);
        end
        shadow_queue = kept;
        return 1'b0;
      end
      default: begin
        if (shadow_queue.size() >= DEF_QUEUE_DEPTH) begin
          reply.kind  = RK_DROP;
          reply.id    = id;
          reply.addr  = addr;
          reply.count = COUNT_W'(shadow_queue.size());
          return 1'b1;
        end
        head.is_write = (op == OP_WRITE);
        head.id       = id;
        head.addr     = addr;
        head.value    = value;
        shadow_queue.push_back(head);
        return 1'b0;
      end
    endcase
  endfunction

  // Addresses cluster on a few words so that reads hit earlier writes and
  // cancels find matches; some sit right at the configured size.
  function automatic logic [ADDR_W-1:0] pick_address();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return ADDR_W'($urandom_range(0, 7));
    if (roll < 55) return ADDR_W'(1023 - $urandom_range(0, 7));
    if (roll < 70) return ADDR_W'(shadow_size) - ADDR_W'($urandom_range(0, 2));
    return ADDR_W'($urandom);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic drive_transaction(input op_t op, input logic [ID_W-1:0] id,
                                   input logic [ADDR_W-1:0] addr,
                                   input logic [DATA_W-1:0] value,
                                   input bit golden, input reply_t want);
    reply_t predicted;
    bit     has_reply;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid    <= 1'b1;
    operation    <= op;
    requester_id <= id;
    address      <= addr;
    write_value  <= value;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    has_reply = queue_memory_step(op, id, addr, value, predicted);
    if (golden) pending_replies.push_back(want);
    else if (has_reply) pending_replies.push_back(predicted);
  endtask

  // Stop offering, drain every expected result, then let in-flight ticks and
  // cancels finish.
  task automatic wait_quiet();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_ram_size(input logic [SIZE_W-1:0] size);
    @(negedge clk);
    ram_size_we    <= 1'b1;
    ram_size_wdata <= size;
    @(posedge clk);
    shadow_set_size(size);
    @(negedge clk);
    ram_size_we <= 1'b0;
  endtask

  task automatic start_hold();
    fork
      begin
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding <= 1'b0;
      end
    join_none
  endtask

  always @(negedge clk) begin
    rsp_stall <= holding || ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d id %0d addr %0d",
                                  result_kind, reply_id, reply_address));
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (result_kind !== oldest_reply.kind || reply_id !== oldest_reply.id ||
            reply_address !== oldest_reply.addr || read_value !== oldest_reply.value ||
            queue_count !== oldest_reply.count) begin
          report_mismatch($sformatf(
            "got kind %0d id %0d addr %0d value %h count %0d, want %0d %0d %0d %h %0d",
            result_kind, reply_id, reply_address, read_value, queue_count,
            oldest_reply.kind, oldest_reply.id, oldest_reply.addr,
            oldest_reply.value, oldest_reply.count));
        end
      end
    end
  end

  // Ends the run when no transaction moves on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[memory_request_queue_cancel] ERROR");
    $finish;
  end

  initial begin
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
    int                roll;

    rst            = 1'b1;
    ram_size_we    = 1'b0;
    ram_size_wdata = RESET_RAM_SIZE;
    req_valid      = 1'b0;
    operation      = OP_TICK;
    requester_id   = '0;
    address        = '0;
    write_value    = '0;
    rsp_stall      = 1'b0;
    holding        = 1'b0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    mismatches     = 0;

    shadow_queue.delete();
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    shadow_size = RESET_RAM_SIZE;

    // Reads at 0x3ff sit next to each other so one cancel must remove both.
    // The eleven reads at 0x2aa fill the queue; the write after them is dropped.
    directed = '{
      '{OP_TICK,   8'h00, 10'h000, 32'h0000_0000, 1,  1'b0, '0},
      '{OP_READ,   8'h00, 10'h000, 32'h0000_0000, 1,  1'b0, '0},
      '{OP_TICK,   8'h00, 10'h000, 32'h0000_0000, 1,  1'b1,
        {RK_READ, 8'h00, 10'h000, 32'h0000_0000, 5'd0}},
      '{OP_WRITE,  8'hff, 10'h3ff, 32'h7fff_ffff, 1,  1'b0, '0},
      '{OP_WRITE,  8'h00, 10'h000, 32'h8000_0000, 1,  1'b0, '0},
      '{OP_READ,   8'h55, 10'h3ff, 32'h0000_0000, 1,  1'b0, '0},
      '{OP_READ,   8'haa, 10'h3ff, 32'h0000_0000, 1,  1'b0, '0},
      '{OP_READ,   8'h01, 10'h000, 32'h0000_0000, 1,  1'b0, '0},
      '{OP_READ,   8'h10, 10'h2aa, 32'hffff_ffff, 11, 1'b0, '0},
      '{OP_WRITE,  8'hff, 10'h2aa, 32'hffff_ffff, 1,  1'b1,
        {RK_DROP, 8'hff, 10'h2aa, 32'h0000_0000, 5'd16}},
      '{OP_CANCEL, 8'h00, 10'h3ff, 32'h0000_0000, 1,  1'b0, '0},
      '{OP_CANCEL, 8'h00, 10'h2aa, 32'h0000_0000, 1,  1'b0, '0},
      '{OP_TICK,   8'h00, 10'h000, 32'h0000_0000, 3,  1'b0, '0}
    };

    ram_sizes = '{11'd1024, 11'd0, 11'd2047, 11'd300, 11'd1, 11'd1023, 11'd16, 11'd0};
    ram_sizes[PHASES-1] = SIZE_W'($urandom_range(0, 2047));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[r]) begin
      for (int k = 0; k < directed[r].copies; k++) begin
        drive_transaction(directed[r].op, ID_W'(directed[r].id + k), directed[r].addr,
                          directed[r].value, directed[r].golden, directed[r].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      write_ram_size(ram_sizes[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      // The output side blocks while the sender keeps offering, so the request
      // channel backs up.
      if (p % 4 == 0) start_hold();

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        // Odd phases favor requests and run the queue full; even ones give ticks more.
        if (p % 2 == 1)
          op = (roll < 40) ? OP_READ : (roll < 75) ? OP_WRITE : (roll < 90) ? OP_TICK
                                                                            : OP_CANCEL;
        else
          op = (roll < 30) ? OP_READ : (roll < 55) ? OP_WRITE : (roll < 90) ? OP_TICK
                                                                            : OP_CANCEL;
        id = ID_W'($urandom_range(0, 255));
        if (op == OP_CANCEL && shadow_queue.size() != 0 && $urandom_range(0, 9) < 7)
          addr = shadow_queue[$urandom_range(0, shadow_queue.size() - 1)].addr;
        else
          addr = pick_address();
        case ($urandom_range(0, 15))
          0: value = 32'h7fff_ffff;
          1: value = 32'h8000_0000;
          2: value = 32'hffff_ffff;
          3: value = 32'h0000_0000;
          default: value = $urandom;
        endcase
        drive_transaction(op, id, addr, value, 1'b0, '0);
      end
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("[memory_request_queue_cancel] OK");
    end else begin
      $display("[memory_request_queue_cancel] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/mrqc_pkg.sv
hdl/mrqc_cell.sv
hdl/mrqc_queue.sv
hdl/mrqc_mem.sv
hdl/memory_request_queue_cancel.sv
verif/tb_memory_request_queue_cancel.sv
